[rtl/core/ldip_pkg.sv]
// ----------------------------------------------------------------------------
// ldip_pkg
// Types and constants shared by the dither interleave packer modules.
// ----------------------------------------------------------------------------
package ldip_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned GRB_W    = 24;
  localparam int unsigned STREAM_W = 48;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CARRY_W  = 16;
  localparam int unsigned SUB_W    = 3;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // Register index as decoded from paddr[2].
  localparam logic REG_SUBFRAME = 1'b0;

  typedef struct packed {
    logic [STREAM_W-1:0] stream;
    logic                frame_end;
  } ldip_entry_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } ldip_q_stat_t;

  typedef enum logic {
    BK_FIRST,
    BK_SECOND
  } ldip_bk_state_t;

  // One channel shows base+1 when its count exceeds the subframe, saturating at 255.
  function automatic logic [CHAN_W-1:0] dither_chan(
    logic [CHAN_W-1:0] base,
    logic [CNT_W-1:0]  cnt,
    logic [SUB_W-1:0]  sub
  );
    logic [CHAN_W-1:0] res;
    res = base;
    if ((cnt > {1'b0, sub}) && (base != {CHAN_W{1'b1}})) begin
      res = base + CHAN_W'(1);
    end
    return res;
  endfunction

endpackage

[rtl/core/ldip_in_if.sv]
// ----------------------------------------------------------------------------
// ldip_in_if
// Input channel: one LED pair per beat with its subframe counts.
// ----------------------------------------------------------------------------
interface ldip_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  string_a_green;
  logic [7:0]  string_a_red;
  logic [7:0]  string_a_blue;
  logic [7:0]  string_b_green;
  logic [7:0]  string_b_red;
  logic [7:0]  string_b_blue;
  logic [11:0] fractions_a;
  logic [11:0] fractions_b;
  logic        frame_end;

  modport source (
    output valid, string_a_green, string_a_red, string_a_blue,
           string_b_green, string_b_red, string_b_blue,
           fractions_a, fractions_b, frame_end,
    input  ready
  );

  modport sink (
    input  valid, string_a_green, string_a_red, string_a_blue,
           string_b_green, string_b_red, string_b_blue,
           fractions_a, fractions_b, frame_end,
    output ready
  );
endinterface

[rtl/core/ldip_out_if.sv]
// ----------------------------------------------------------------------------
// ldip_out_if
// Result channel: one packed 32-bit word per beat.
// ----------------------------------------------------------------------------
interface ldip_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        last_word;

  modport source (
    output valid, out_word, last_word,
    input  ready
  );

  modport sink (
    input  valid, out_word, last_word,
    output ready
  );
endinterface

[rtl/core/led_dither_interleave_packer.sv]
// ----------------------------------------------------------------------------
// led_dither_interleave_packer
// Temporal dither of two LED strings, bit interleave and 32-bit word packing.
// ----------------------------------------------------------------------------
//   Channel   Port prefix   Direction   Beat
//   input     in_ch         sink        one LED pair with subframe counts
//   result    out_ch        source      one 32-bit packed word, last flag
//   config    p*            APB slave   subframe_number at byte address 0
//
// One word leaves the output register per cycle while out_ch does not stall.
// A pair gives one word, or two when half a word was held or the frame ends on
// it. The first word of a pair passes through the queue and then the output
// register before it is presented.
// Synchronous active-low reset clears the queue, carry and output valid.
// in_ch.ready drops only when the queue is full; out_ch stalls hold the word.
// ----------------------------------------------------------------------------
module led_dither_interleave_packer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ldip_in_if.sink                        in_ch,
  ldip_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ldip_pkg::ADDR_W-1:0]    paddr,
  input  logic [ldip_pkg::DATA_W-1:0]    pwdata,
  output logic [ldip_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  logic [ldip_pkg::SUB_W-1:0] subframe_r, subframe_nxt;
  logic                       cfg_wr;
  logic                       push;
  logic                       pop;
  ldip_pkg::ldip_entry_t      push_entry;
  ldip_pkg::ldip_entry_t      head;
  ldip_pkg::ldip_q_stat_t     q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    subframe_nxt = subframe_r;
    if (cfg_wr && (paddr[2] == ldip_pkg::REG_SUBFRAME)) begin
      subframe_nxt = pwdata[ldip_pkg::SUB_W-1:0];
    end
    prdata = '0;
    if (paddr[2] == ldip_pkg::REG_SUBFRAME) begin
      prdata = {{(ldip_pkg::DATA_W - ldip_pkg::SUB_W){1'b0}}, subframe_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subframe_r <= '0;
    end else begin
      subframe_r <= subframe_nxt;
    end
  end

  ldip_front u_front (
    .in_ch      (in_ch),
    .subframe   (subframe_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  ldip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  ldip_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

[rtl/core/ldip_front.sv]
// ----------------------------------------------------------------------------
// ldip_front
// Accepts LED pairs, applies temporal dither and interleaves the two strings.
// ----------------------------------------------------------------------------
module ldip_front (
  ldip_in_if.sink                        in_ch,
  input  logic [ldip_pkg::SUB_W-1:0]     subframe,
  input  ldip_pkg::ldip_q_stat_t         q_stat,
  output logic                           push,
  output ldip_pkg::ldip_entry_t          push_entry
);

  logic [ldip_pkg::GRB_W-1:0] word_a;
  logic [ldip_pkg::GRB_W-1:0] word_b;

  assign in_ch.ready = q_stat.not_full;
  assign push        = in_ch.valid && q_stat.not_full;

  always_comb begin
    word_a = {ldip_pkg::dither_chan(in_ch.string_a_green, in_ch.fractions_a[11:8], subframe),
              ldip_pkg::dither_chan(in_ch.string_a_red,   in_ch.fractions_a[7:4],  subframe),
              ldip_pkg::dither_chan(in_ch.string_a_blue,  in_ch.fractions_a[3:0],  subframe)};
    word_b = {ldip_pkg::dither_chan(in_ch.string_b_green, in_ch.fractions_b[11:8], subframe),
              ldip_pkg::dither_chan(in_ch.string_b_red,   in_ch.fractions_b[7:4],  subframe),
              ldip_pkg::dither_chan(in_ch.string_b_blue,  in_ch.fractions_b[3:0],  subframe)};
  end

  // The second string's bit goes out ahead of the first string's bit.
  always_comb begin
    for (int j = 0; j < ldip_pkg::GRB_W; j++) begin
      push_entry.stream[2*j+1] = word_b[j];
      push_entry.stream[2*j]   = word_a[j];
    end
    push_entry.frame_end = in_ch.frame_end;
  end

endmodule

[rtl/core/ldip_queue.sv]
// ----------------------------------------------------------------------------
// ldip_queue
// Small FIFO of interleaved bit streams between the front and back parts.
// ----------------------------------------------------------------------------
module ldip_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  ldip_pkg::ldip_entry_t   push_entry,
  input  logic                    pop,
  output ldip_pkg::ldip_entry_t   head,
  output ldip_pkg::ldip_q_stat_t  q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ldip_pkg::ldip_entry_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.not_full  = (count_r != CNT_W'(DEPTH));
  assign q_stat.not_empty = (count_r != '0);
  assign head             = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CNT_W'(DEPTH)))
    else $error("queue pushed while full");

endmodule

[rtl/core/ldip_back.sv]
// ----------------------------------------------------------------------------
// ldip_back
// Packs 48-bit streams into 32-bit words, holding 16 bits between pairs.
// ----------------------------------------------------------------------------
module ldip_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ldip_pkg::ldip_entry_t   head,
  input  ldip_pkg::ldip_q_stat_t  q_stat,
  output logic                    pop,
  ldip_out_if.source              out_ch
);

  ldip_pkg::ldip_bk_state_t state_r, state_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [ldip_pkg::WORD_W-1:0]   out_word_r, out_word_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [ldip_pkg::WORD_W-1:0]   sec_word_r, sec_word_nxt;
  logic                          sec_last_r, sec_last_nxt;
  logic [ldip_pkg::CARRY_W-1:0]  carry_bits_r, carry_bits_nxt;
  logic                          carry_valid_r, carry_valid_nxt;
  logic                          load;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_word  = out_word_r;
  assign out_ch.last_word = out_last_r;

  // The output register takes a new word when empty or when its beat is taken.
  assign load = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    out_word_nxt    = out_word_r;
    out_last_nxt    = out_last_r;
    sec_word_nxt    = sec_word_r;
    sec_last_nxt    = sec_last_r;
    carry_bits_nxt  = carry_bits_r;
    carry_valid_nxt = carry_valid_r;
    pop             = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ldip_pkg::BK_SECOND: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = sec_word_r;
          out_last_nxt  = sec_last_r;
          state_nxt     = ldip_pkg::BK_FIRST;
        end
      end
      ldip_pkg::BK_FIRST: begin
        if (load && q_stat.not_empty) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          if (carry_valid_r) begin
            out_word_nxt    = {carry_bits_r, head.stream[47:32]};
            sec_word_nxt    = head.stream[31:0];
            sec_last_nxt    = head.frame_end;
            carry_valid_nxt = 1'b0;
            state_nxt       = ldip_pkg::BK_SECOND;
          end else begin
            out_word_nxt = head.stream[47:16];
            if (head.frame_end) begin
              // Flush the leftover half word padded with zeros.
              sec_word_nxt    = {head.stream[15:0], 16'h0000};
              sec_last_nxt    = 1'b1;
              carry_valid_nxt = 1'b0;
              state_nxt       = ldip_pkg::BK_SECOND;
            end else begin
              carry_bits_nxt  = head.stream[15:0];
              carry_valid_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ldip_pkg::BK_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ldip_pkg::BK_FIRST;
      out_valid_r   <= 1'b0;
      carry_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      carry_valid_r <= carry_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
    sec_word_r   <= sec_word_nxt;
    sec_last_r   <= sec_last_nxt;
    carry_bits_r <= carry_bits_nxt;
  end

  a_second_has_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ldip_pkg::BK_SECOND) |-> out_valid_r)
    else $error("second word pending without a first word in the output register");

  a_no_carry_in_second: assert property (@(posedge clk) disable iff (!rst_n)
    !(carry_valid_r && (state_r == ldip_pkg::BK_SECOND)))
    else $error("carry held while a second word is pending");

  a_last_clears_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !carry_valid_r)
    else $error("frame ended with carry bits still held");

endmodule
